@@ design/casw_pkg.sv @@
// casw_pkg: shared types, codes and helpers of the cumulative ack sender window
// no dependencies

package casw_pkg;

    localparam int RING_DEPTH_DEF = 16;
    localparam int SEQ_W          = 64;
    localparam int LEN_W          = 16;
    localparam int HDR_W          = 8;
    localparam int TX_SLOT_W      = 4;

    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [1:0] TX_NONE   = 2'd0;
    localparam logic [1:0] TX_NEW    = 2'd1;
    localparam logic [1:0] TX_RESEND = 2'd2;

    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;
    localparam logic [1:0] TMR_RESTART = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [HDR_W-1:0] HDR_RESET = 8'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_FIN
    } casw_state_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_PUSH,
        CM_SHIFT,
        CM_ROTATE
    } casw_mode_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
    } casw_desc_t;

    typedef struct packed {
        casw_mode_t mode;
        casw_desc_t new_desc;
    } casw_cmd_t;

    function automatic logic [LEN_W-1:0] payload_len(input logic [LEN_W-1:0] len,
                                                     input logic [HDR_W-1:0] hdr);
        logic [LEN_W-1:0] hdr_ext;
        hdr_ext = LEN_W'(hdr);
        payload_len = (len > hdr_ext) ? (len - hdr_ext) : '0;
    endfunction

endpackage

@@ design/casw_cell.sv @@
// casw_cell: one descriptor cell of the outstanding segment chain
// depends on casw_pkg

module casw_cell #(
    parameter int RING_DEPTH = casw_pkg::RING_DEPTH_DEF,
    parameter int IDX        = 0,
    parameter int CNT_W      = $clog2(RING_DEPTH + 1),
    parameter int SLOT_W     = $clog2(RING_DEPTH)
) (
    input  logic                 clk,
    input  casw_pkg::casw_cmd_t  cmd,
    input  logic [CNT_W-1:0]     count,
    input  logic [SLOT_W-1:0]    new_slot,
    input  casw_pkg::casw_desc_t head_desc,
    input  logic [SLOT_W-1:0]    head_slot,
    input  casw_pkg::casw_desc_t nbr_desc,
    input  logic [SLOT_W-1:0]    nbr_slot,
    output casw_pkg::casw_desc_t desc,
    output logic [SLOT_W-1:0]    slot
);
    import casw_pkg::*;

    casw_desc_t        desc_reg;
    casw_desc_t        desc_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    always_comb
    begin
        desc_next = desc_reg;
        slot_next = slot_reg;
        case (cmd.mode)
            CM_PUSH:
            begin
                if (count == CNT_W'(IDX))
                begin
                    desc_next = cmd.new_desc;
                    slot_next = new_slot;
                end
            end
            CM_SHIFT:
            begin
                desc_next = nbr_desc;
                slot_next = nbr_slot;
            end
            CM_ROTATE:
            begin
                // last live cell wraps around to the head
                if (count == CNT_W'(IDX + 1))
                begin
                    desc_next = head_desc;
                    slot_next = head_slot;
                end
                else
                begin
                    desc_next = nbr_desc;
                    slot_next = nbr_slot;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        slot_reg <= slot_next;
    end

    assign desc = desc_reg;
    assign slot = slot_reg;

endmodule

@@ design/cumulative_ack_sender_window.sv @@
// cumulative_ack_sender_window: top level, control sequencer and chain of descriptor cells
// depends on casw_pkg and casw_cell
// steps: S_IDLE accepts, S_FIN registers the result; an ack that raises the base pops in
// S_POP first; a timeout with segments outstanding does one rotation per cycle in S_SCAN
// throughput: one item at a time, next taken once its result sits in the output register
// reset: async clear of pointers, count, sequence numbers and timer; header length 16

module cumulative_ack_sender_window #(
    parameter int RING_DEPTH = casw_pkg::RING_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     op,
    input  logic [casw_pkg::LEN_W-1:0]     seg_len,
    input  logic [casw_pkg::SEQ_W-1:0]     ack_number,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     tx_kind,
    output logic [casw_pkg::SEQ_W-1:0]     tx_seq,
    output logic [casw_pkg::LEN_W-1:0]     tx_len,
    output logic [casw_pkg::TX_SLOT_W-1:0] tx_slot,
    output logic [1:0]                     timer_cmd,
    output logic [1:0]                     status,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [casw_pkg::HDR_W-1:0]     cfg_data
);
    import casw_pkg::*;

    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SLOT_W = $clog2(RING_DEPTH);

    casw_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [SEQ_W-1:0]  base_reg, base_next;
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic              timer_on_reg, timer_on_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;

    logic [1:0]        op_reg, op_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [SEQ_W-1:0]  ack_reg, ack_next;

    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              found_reg, found_next;
    casw_desc_t        pick_reg, pick_next;
    logic [SLOT_W-1:0] pick_slot_reg, pick_slot_next;

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [LEN_W-1:0]  olen_reg, olen_next;
    logic [TX_SLOT_W-1:0] oslot_reg, oslot_next;
    logic [1:0]        tcmd_reg, tcmd_next;
    logic [1:0]        status_reg, status_next;

    casw_cmd_t         cmd;
    casw_desc_t        cell_desc [RING_DEPTH];
    logic [SLOT_W-1:0] cell_slot [RING_DEPTH];

    logic              in_fire;
    logic              out_free;
    logic [SEQ_W-1:0]  head_end;
    logic              pop_ok;
    logic              head_match;
    logic              ring_full;

    assign in_fire    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign head_end   = cell_desc[0].seq + SEQ_W'(payload_len(cell_desc[0].len, hdr_reg));
    assign pop_ok     = (count_reg != '0) && (head_end <= ack_reg);
    assign head_match = (cell_desc[0].seq <= base_reg) && (base_reg < head_end);
    assign ring_full  = (count_reg == CNT_W'(RING_DEPTH));

    // descriptor chain
    genvar gi;
    generate
        for (gi = 0; gi < RING_DEPTH; gi++)
        begin : g_cell
            casw_desc_t        nbr_desc;
            logic [SLOT_W-1:0] nbr_slot;
            if (gi == RING_DEPTH - 1)
            begin : g_last
                assign nbr_desc = cell_desc[0];
                assign nbr_slot = cell_slot[0];
            end
            else
            begin : g_mid
                assign nbr_desc = cell_desc[gi + 1];
                assign nbr_slot = cell_slot[gi + 1];
            end
            casw_cell #(
                .RING_DEPTH (RING_DEPTH),
                .IDX        (gi)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .count     (count_reg),
                .new_slot  (tail_reg),
                .head_desc (cell_desc[0]),
                .head_slot (cell_slot[0]),
                .nbr_desc  (nbr_desc),
                .nbr_slot  (nbr_slot),
                .desc      (cell_desc[gi]),
                .slot      (cell_slot[gi])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (op == OP_ACK && ack_number > base_reg)
                        state_next = S_POP;
                    else if (op == OP_TIMEOUT && count_reg != '0)
                        state_next = S_SCAN;
                    else
                        state_next = S_FIN;
                end
            end
            S_POP:
            begin
                if (!pop_ok)
                    state_next = S_FIN;
            end
            S_SCAN:
            begin
                if (scan_reg == count_reg - 1'b1)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        tail_next      = tail_reg;
        base_next      = base_reg;
        next_seq_next  = next_seq_reg;
        timer_on_next  = timer_on_reg;
        hdr_next       = hdr_reg;
        op_next        = op_reg;
        len_next       = len_reg;
        ack_next       = ack_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_slot_next = pick_slot_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        seq_next       = seq_reg;
        olen_next      = olen_reg;
        oslot_next     = oslot_reg;
        tcmd_next      = tcmd_reg;
        status_next    = status_reg;
        cmd.mode       = CM_HOLD;
        cmd.new_desc.seq = next_seq_reg;
        cmd.new_desc.len = len_reg;

        if (cfg_valid)
            hdr_next = cfg_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next   = op;
                    len_next  = seg_len;
                    ack_next  = ack_number;
                    scan_next = '0;
                    if (op == OP_ACK && ack_number > base_reg)
                        base_next = ack_number;
                end
            end
            S_POP:
            begin
                if (pop_ok)
                begin
                    cmd.mode   = CM_SHIFT;
                    count_next = count_reg - 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.mode  = CM_ROTATE;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == '0)
                begin
                    pick_next      = cell_desc[0];
                    pick_slot_next = cell_slot[0];
                    found_next     = head_match;
                end
                else if (!found_reg && head_match)
                begin
                    pick_next      = cell_desc[0];
                    pick_slot_next = cell_slot[0];
                    found_next     = 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = TX_NONE;
                    seq_next       = '0;
                    olen_next      = '0;
                    oslot_next     = '0;
                    tcmd_next      = TMR_NONE;
                    status_next    = ST_DONE;
                    case (op_reg)
                        OP_SEND:
                        begin
                            if (len_reg == '0)
                                status_next = ST_IGNORED;
                            else if (ring_full)
                                status_next = ST_FULL;
                            else
                            begin
                                cmd.mode      = CM_PUSH;
                                kind_next     = TX_NEW;
                                seq_next      = next_seq_reg;
                                olen_next     = len_reg;
                                oslot_next    = TX_SLOT_W'(tail_reg);
                                next_seq_next = next_seq_reg
                                                + SEQ_W'(payload_len(len_reg, hdr_reg));
                                count_next    = count_reg + 1'b1;
                                tail_next     = (tail_reg == SLOT_W'(RING_DEPTH - 1))
                                                ? '0 : tail_reg + 1'b1;
                                if (!timer_on_reg)
                                begin
                                    tcmd_next     = TMR_START;
                                    timer_on_next = 1'b1;
                                end
                            end
                        end
                        OP_ACK:
                        begin
                            if (base_reg == next_seq_reg)
                            begin
                                if (timer_on_reg)
                                begin
                                    tcmd_next     = TMR_STOP;
                                    timer_on_next = 1'b0;
                                end
                            end
                            else
                            begin
                                tcmd_next     = timer_on_reg ? TMR_RESTART : TMR_START;
                                timer_on_next = 1'b1;
                            end
                        end
                        OP_TIMEOUT:
                        begin
                            if (count_reg == '0)
                                status_next = ST_IGNORED;
                            else
                            begin
                                kind_next     = TX_RESEND;
                                seq_next      = pick_reg.seq;
                                olen_next     = pick_reg.len;
                                oslot_next    = TX_SLOT_W'(pick_slot_reg);
                                tcmd_next     = timer_on_reg ? TMR_RESTART : TMR_START;
                                timer_on_next = 1'b1;
                            end
                        end
                        default:
                            status_next = ST_IGNORED;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            tail_reg      <= '0;
            base_reg      <= '0;
            next_seq_reg  <= '0;
            timer_on_reg  <= 1'b0;
            hdr_reg       <= HDR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tail_reg      <= tail_next;
            base_reg      <= base_next;
            next_seq_reg  <= next_seq_next;
            timer_on_reg  <= timer_on_next;
            hdr_reg       <= hdr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        len_reg       <= len_next;
        ack_reg       <= ack_next;
        scan_reg      <= scan_next;
        found_reg     <= found_next;
        pick_reg      <= pick_next;
        pick_slot_reg <= pick_slot_next;
        kind_reg      <= kind_next;
        seq_reg       <= seq_next;
        olen_reg      <= olen_next;
        oslot_reg     <= oslot_next;
        tcmd_reg      <= tcmd_next;
        status_reg    <= status_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign tx_kind   = kind_reg;
    assign tx_seq    = seq_reg;
    assign tx_len    = olen_reg;
    assign tx_slot   = oslot_reg;
    assign timer_cmd = tcmd_reg;
    assign status    = status_reg;

endmodule
